// ----- src/radix_sort_base_count_assert.svh -----
// Assertion macros for the radix sort block.
// Used by radix_sort_base_count.sv; needs clk_i and rst_ni in scope.
`ifndef RADIX_SORT_BASE_COUNT_ASSERT_SVH
`define RADIX_SORT_BASE_COUNT_ASSERT_SVH
`ifndef SYNTHESIS
`define RSBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define RSBC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
  else $error(msg);
`else
`define RSBC_ASSERT(lbl, prop, msg)
`define RSBC_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

// ----- src/rsbc_pkg.sv -----
// Package for the radix sort block: beat types and defaults.
// No dependencies.
`default_nettype none
package rsbc_pkg;
  localparam int MaxItems   = 64;
  localparam int ValueWidth = 16;
  localparam logic [4:0] DigitPassesReset = 5'd3;

  typedef struct packed {
    logic [15:0] value;
    logic        last;
  } in_t;

  typedef struct packed {
    logic [15:0] sorted_value;
    logic        last_out;
  } out_t;
endpackage
`default_nettype wire

// ----- src/rsbc_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Standalone; used by radix_sort_base_count.
`default_nettype none
module rsbc_div #(
  parameter int VW = 16,
  parameter int CW = 7
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [VW-1:0] dividend_i,
  input  wire logic [CW-1:0] divisor_i,
  output logic               done_o,
  output logic [VW-1:0]      quo_o,
  output logic [CW-1:0]      rem_o
);
  localparam int SW = $clog2(VW + 1);

  logic          busy_q, busy_d, done_q, done_d;
  logic [SW-1:0] step_q, step_d;
  logic [VW-1:0] quo_q, quo_d;
  logic [CW-1:0] rem_q, rem_d, div_q, div_d;
  logic [CW:0]   trial;

  assign trial = {rem_q, quo_q[VW-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = SW'(VW);
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = CW'(trial - {1'b0, div_q});
        quo_d = {quo_q[VW-2:0], 1'b1};
      end else begin
        rem_d = trial[CW-1:0];
        quo_d = {quo_q[VW-2:0], 1'b0};
      end
      step_d = step_q - SW'(1);
      if (step_q == SW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
endmodule
`default_nettype wire

// ----- src/radix_sort_base_count.sv -----
// Radix sort, base = item count n. Load: one beat per cycle, no result.
// Sort after the last beat: init, then per digit pass a clear, a
// divide and count per item (divider, one quotient bit a cycle), a
// prefix sum, a backward scatter and a copy; then emit. Input stalls
// from the last beat until the final result is loaded into the output register.
// Reset clears control and the pass register (3); stores are not cleared.
`default_nettype none
module radix_sort_base_count #(
  parameter int MAX_ITEMS   = rsbc_pkg::MaxItems,
  parameter int VALUE_WIDTH = rsbc_pkg::ValueWidth
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire rsbc_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output rsbc_pkg::out_t      out_data_o,
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic [4:0]     cfg_data_i
);
  import rsbc_pkg::*;

  localparam int VW = VALUE_WIDTH;
  localparam int CW = $clog2(MAX_ITEMS + 1);  // counts up to MAX_ITEMS
  localparam int IW = $clog2(MAX_ITEMS);      // entry index

  typedef enum logic [4:0] {
    IDLE, INIT_RD, INIT_WR, PASS_CHK, CLR, DIV_RD, DIV_GO, DIV_WAIT,
    CNT_RD, CNT_INC, PRE_RD, PRE_WR, SC_RD1, SC_RD2, SC_WR,
    CP_RD, CP_WR, OUT_RD, OUT_VAL, OUT_EMIT
  } state_e;

  state_e        state_q;
  logic [CW-1:0] count_q;  // items loaded
  logic [CW-1:0] n_q;      // radix of this run
  logic [IW-1:0] idx_q;
  logic [IW-1:0] dig_q;
  logic [CW-1:0] acc_q;
  logic [4:0]    pass_q;
  logic [4:0]    passes_q;
  logic          out_valid_q;
  out_t          out_q;

  // storage
  logic [VW-1:0] val_mem  [MAX_ITEMS];
  logic [VW-1:0] res_mem  [MAX_ITEMS];
  logic [VW-1:0] nres_mem [MAX_ITEMS];
  logic [IW-1:0] ord_mem  [MAX_ITEMS];
  logic [IW-1:0] nord_mem [MAX_ITEMS];
  logic [IW-1:0] dig_mem  [MAX_ITEMS];
  logic [CW-1:0] cnt_mem  [MAX_ITEMS];

  logic [VW-1:0] val_rd, res_rd, nres_rd;
  logic [IW-1:0] ord_rd, nord_rd, dig_rd;
  logic [CW-1:0] cnt_rd;

  logic          div_start, div_done;
  logic [VW-1:0] div_quo;
  logic [CW-1:0] div_rem;

  logic          in_acc, out_acc, idx_end;
  logic [IW-1:0] val_ra, cnt_ra, cnt_wa, pos;
  logic          val_we, res_we, ord_we, cnt_we, new_we, dig_we;
  logic [VW-1:0] res_wd;
  logic [IW-1:0] ord_wd;
  logic [CW-1:0] cnt_wd, acc_sum;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_q && !out_stall_i;
  assign in_stall_o  = (state_q != IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign idx_end     = ({1'b0, idx_q} == CW'(n_q - CW'(1)));
  assign acc_sum     = acc_q + cnt_rd;
  assign pos         = IW'(cnt_rd - CW'(1));  // scatter slot
  assign div_start   = (state_q == DIV_GO);

  rsbc_div #(.VW(VW), .CW(CW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (res_rd),
    .divisor_i  (n_q),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // address and write-port steering
  always_comb begin
    val_ra = (state_q == OUT_VAL || state_q == OUT_EMIT) ? ord_rd : idx_q;
    cnt_ra = idx_q;
    cnt_wa = idx_q;
    cnt_wd = '0;
    cnt_we = 1'b0;
    case (state_q)
      CNT_RD, CNT_INC: begin
        cnt_ra = dig_q;
        cnt_wa = dig_q;
        cnt_wd = cnt_rd + CW'(1);
        cnt_we = (state_q == CNT_INC);
      end
      SC_RD2, SC_WR: begin
        cnt_ra = dig_rd;
        cnt_wa = dig_rd;
        cnt_wd = cnt_rd - CW'(1);
        cnt_we = (state_q == SC_WR);
      end
      CLR: begin
        cnt_we = 1'b1;
      end
      PRE_WR: begin
        cnt_wd = acc_sum;
        cnt_we = 1'b1;
      end
      default: begin
      end
    endcase
    val_we = (state_q == IDLE) && in_acc && (count_q < CW'(MAX_ITEMS));
    dig_we = (state_q == DIV_WAIT) && div_done;
    res_we = (state_q == INIT_WR) || dig_we || (state_q == CP_WR);
    res_wd = (state_q == INIT_WR) ? val_rd : (dig_we ? div_quo : nres_rd);
    ord_we = (state_q == INIT_WR) || (state_q == CP_WR);
    ord_wd = (state_q == INIT_WR) ? idx_q : nord_rd;
    new_we = (state_q == SC_WR);
  end

  always_ff @(posedge clk_i) begin
    if (val_we) val_mem[count_q[IW-1:0]] <= VW'(in_data_i.value);
    val_rd <= val_mem[val_ra];
  end

  always_ff @(posedge clk_i) begin
    if (res_we) res_mem[idx_q] <= res_wd;
    res_rd <= res_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (ord_we) ord_mem[idx_q] <= ord_wd;
    ord_rd <= ord_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (dig_we) dig_mem[idx_q] <= div_rem[IW-1:0];
    dig_rd <= dig_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    cnt_rd <= cnt_mem[cnt_ra];
  end

  always_ff @(posedge clk_i) begin
    if (new_we) begin
      nres_mem[pos] <= res_rd;
      nord_mem[pos] <= ord_rd;
    end
    nres_rd <= nres_mem[idx_q];
    nord_rd <= nord_mem[idx_q];
  end

  // sequencer: load, init, passes (clear, divide+count, prefix, scatter, copy), emit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      count_q     <= '0;
      n_q         <= '0;
      idx_q       <= '0;
      dig_q       <= '0;
      acc_q       <= '0;
      pass_q      <= '0;
      passes_q    <= DigitPassesReset;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) passes_q <= cfg_data_i;
      // in OUT_EMIT an accepted beat is always replaced by the next one
      if (out_acc && state_q != OUT_EMIT) out_valid_q <= 1'b0;
      case (state_q)
        IDLE: begin
          if (in_acc) begin
            if (count_q < CW'(MAX_ITEMS)) count_q <= count_q + CW'(1);
            if (in_data_i.last) begin
              n_q     <= (count_q < CW'(MAX_ITEMS)) ? count_q + CW'(1) : count_q;
              idx_q   <= '0;
              state_q <= INIT_RD;
            end
          end
        end
        INIT_RD: state_q <= INIT_WR;
        INIT_WR: begin
          idx_q   <= idx_q + IW'(1);
          state_q <= idx_end ? PASS_CHK : INIT_RD;
        end
        PASS_CHK: begin
          idx_q   <= '0;
          state_q <= (pass_q == passes_q) ? OUT_RD : CLR;
        end
        CLR: begin
          idx_q   <= idx_end ? '0 : idx_q + IW'(1);
          state_q <= idx_end ? DIV_RD : CLR;
        end
        DIV_RD: state_q <= DIV_GO;
        DIV_GO: state_q <= DIV_WAIT;
        DIV_WAIT: begin
          if (div_done) begin
            dig_q   <= div_rem[IW-1:0];
            state_q <= CNT_RD;
          end
        end
        CNT_RD: state_q <= CNT_INC;
        CNT_INC: begin
          acc_q   <= '0;
          idx_q   <= idx_end ? '0 : idx_q + IW'(1);
          state_q <= idx_end ? PRE_RD : DIV_RD;
        end
        PRE_RD: state_q <= PRE_WR;
        PRE_WR: begin
          acc_q <= acc_sum;
          if (idx_end) begin
            state_q <= SC_RD1;
          end else begin
            idx_q   <= idx_q + IW'(1);
            state_q <= PRE_RD;
          end
        end
        // walk back so equal digits keep their order
        SC_RD1: state_q <= SC_RD2;
        SC_RD2: state_q <= SC_WR;
        SC_WR: begin
          if (idx_q == '0) begin
            state_q <= CP_RD;
          end else begin
            idx_q   <= idx_q - IW'(1);
            state_q <= SC_RD1;
          end
        end
        CP_RD: state_q <= CP_WR;
        CP_WR: begin
          if (idx_end) begin
            pass_q  <= pass_q + 5'd1;
            state_q <= PASS_CHK;
          end else begin
            idx_q   <= idx_q + IW'(1);
            state_q <= CP_RD;
          end
        end
        OUT_RD:  state_q <= OUT_VAL;
        OUT_VAL: state_q <= OUT_EMIT;
        OUT_EMIT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q        <= 1'b1;
            out_q.sorted_value <= 16'(val_rd);
            out_q.last_out     <= idx_end;
            if (idx_end) begin
              count_q <= '0;
              pass_q  <= '0;
              state_q <= IDLE;
            end else begin
              idx_q   <= idx_q + IW'(1);
              state_q <= OUT_RD;
            end
          end
        end
        default: state_q <= IDLE;
      endcase
    end
  end

`include "radix_sort_base_count_assert.svh"

  `RSBC_ASSERT(a_last_stalls, in_acc && in_data_i.last |=> in_stall_o, "input open after last")
  `RSBC_ASSERT(a_count_cap, count_q <= CW'(MAX_ITEMS), "item count past capacity")
  `RSBC_ASSERT_IMPL(a_digit_range, state_q == CNT_RD, {1'b0, dig_q} < n_q, "digit past radix")
  `RSBC_ASSERT_IMPL(a_radix_nonzero, state_q != IDLE, n_q != '0, "zero radix while sorting")

endmodule
`default_nettype wire

// ----- sim/radix_sort_base_count_checker.sv -----
// Checker for radix_sort_base_count: watches the input, output and register
// channels, predicts sorted beats and compares them. Depends on rsbc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module radix_sort_base_count_checker (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           in_stall_i,
  input  wire rsbc_pkg::in_t  in_data_i,
  input  wire logic           out_valid_i,
  input  wire logic           out_stall_i,
  input  wire rsbc_pkg::out_t out_data_i,
  input  wire logic           cfg_valid_i,
  input  wire logic           cfg_ready_i,
  input  wire logic [4:0]     cfg_data_i,
  output int                  errors_o,
  output int                  pending_o
);
  import rsbc_pkg::*;

  logic [15:0] loaded_vals[$];
  logic [4:0]  passes_q;
  out_t        sorted_q[$];

  assign pending_o = sorted_q.size();

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors_o++;
  endtask

  // LSD radix sort, base = set size, stable counting sort per digit
  task automatic sort_set();
    int n, p, i, k, pos;
    int order[], resid[], nord[], nres[], dig[], cnt[];
    out_t b;
    n = loaded_vals.size();
    order = new[n]; resid = new[n]; nord = new[n]; nres = new[n];
    dig = new[n]; cnt = new[n];
    for (i = 0; i < n; i++) begin
      order[i] = i;
      resid[i] = loaded_vals[i];
    end
    for (p = 0; p < passes_q; p++) begin
      for (i = 0; i < n; i++) cnt[i] = 0;
      for (i = 0; i < n; i++) begin
        dig[i] = resid[i] % n;
        resid[i] = resid[i] / n;
        cnt[dig[i]]++;
      end
      for (i = 1; i < n; i++) cnt[i] += cnt[i-1];
      for (k = n - 1; k >= 0; k--) begin
        cnt[dig[k]]--;
        pos = cnt[dig[k]];
        nord[pos] = order[k];
        nres[pos] = resid[k];
      end
      order = nord;
      resid = nres;
    end
    for (i = 0; i < n; i++) begin
      b.sorted_value = loaded_vals[order[i]];
      b.last_out = (i == n - 1);
      sorted_q.push_back(b);
    end
    loaded_vals.delete();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t exp_b;
    if (!rst_ni) begin
      passes_q = DigitPassesReset;
      loaded_vals.delete();
      sorted_q.delete();
      errors_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) passes_q = cfg_data_i;
      if (out_valid_i && !out_stall_i) begin
        if (sorted_q.size() == 0) begin
          report($sformatf("unexpected beat %h", out_data_i));
        end else begin
          exp_b = sorted_q.pop_front();
          if (out_data_i.sorted_value !== exp_b.sorted_value)
            report($sformatf("sorted_value %h, want %h",
                             out_data_i.sorted_value, exp_b.sorted_value));
          if (out_data_i.last_out !== exp_b.last_out)
            report($sformatf("last_out %b, want %b",
                             out_data_i.last_out, exp_b.last_out));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        // beats past capacity are dropped
        if (loaded_vals.size() < MaxItems) loaded_vals.push_back(in_data_i.value);
        if (in_data_i.last) sort_set();
      end
    end
  end
endmodule
`default_nettype wire

// ----- sim/radix_sort_base_count_tb.sv -----
// Testbench top for radix_sort_base_count: drives sets of values and pass
// settings; the checker module predicts and compares. Depends on rsbc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module radix_sort_base_count_tb;
  import rsbc_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  in_t  in_data_i = '0;
  logic out_stall_i = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [4:0] cfg_data_i = '0;
  logic in_stall_o, out_valid_o, cfg_ready_o;
  out_t out_data_o;
  int   errors, pending;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   sent_vals = 0;

  always #4 clk_i = ~clk_i;

  radix_sort_base_count DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  radix_sort_base_count_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .errors_o(errors), .pending_o(pending)
  );

  // receiver stalls at random, rate set per phase
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // one beat; random idle cycles ahead of it, then hold until accepted
  task automatic send_beat(input logic [15:0] v, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{value: v, last: lst};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    sent_vals++;
  endtask

  // the next beat or a drain takes valid over at the same falling edge
  task automatic send_set(input int n, input int mode);
    logic [15:0] v;
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: v = $urandom_range(65535);
        1: v = $urandom_range(n * n - 1 < 65535 ? n * n - 1 : 65535);
        2: v = $urandom_range(3) == 0 ? 16'hffff : 16'h0000;
        default: v = $urandom_range(7);
      endcase
      send_beat(v, i == n - 1);
    end
  endtask

  // block idle: all results out, then wait out any sort still running
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_passes(input logic [4:0] d);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 64 + $urandom_range(6);   // overflow, extras dropped
    if (r < 20) return $urandom_range(40, 64);
    return $urandom_range(1, 12);
  endfunction

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset passes, single item, extremes, zero, 16, 31 and one pass
    send_beat(16'hffff, 1'b1);
    send_beat(16'h0000, 1'b0);
    send_beat(16'hffff, 1'b0);
    send_beat(16'h5555, 1'b0);
    send_beat(16'haaaa, 1'b1);
    write_passes(5'd0);
    send_set(5, 0);
    write_passes(5'd16);
    send_set(4, 2);
    write_passes(5'd31);
    send_set(3, 3);
    write_passes(5'd1);
    send_set(2, 0);

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      write_passes(ph == 0 ? 5'd3 : ph == 7 ? 5'd16 : 5'($urandom_range(31)));
      while (sent_vals < 80 + ph * 60) begin
        send_set(pick_size(), $urandom_range(3));
        if ($urandom_range(9) == 0) drain();
      end
    end
    drain();
    repeat (50) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("PASS radix_sort_base_count");
    end else begin
      $display("FAIL radix_sort_base_count");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("FAIL radix_sort_base_count");
    $finish;
  end
endmodule
`default_nettype wire
